// ===== src/tvbp_pkg.sv =====
// types and constants shared by the typed value bit packer
// used by tvbp_merge and typed_value_bit_packer_unit; no dependencies
`default_nettype none

package tvbp_pkg;

	typedef enum logic [2:0] {
		OP_RAW     = 3'd0,
		OP_BIT     = 3'd1,
		OP_UVARINT = 3'd2,
		OP_SVARINT = 3'd3,
		OP_ID      = 3'd4,
		OP_POS     = 3'd5,
		OP_ENUM    = 3'd6,
		OP_FLUSH   = 3'd7
	} opcode_t;

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_PREFIX  = 6'b000010,
		S_PAYLOAD = 6'b000100,
		S_VARINT  = 6'b001000,
		S_FLUSH   = 6'b010000,
		S_DONE    = 6'b100000
	} state_t;

	// result of merging one segment into the partial byte
	typedef struct packed {
		logic       emit;
		logic [7:0] data;
		logic [7:0] part;
		logic [2:0] fill;
	} merge_t;

	// prefix codes, left-aligned in a byte
	localparam logic [7:0] PRE_0   = 8'h00;
	localparam logic [7:0] PRE_10  = 8'h80;
	localparam logic [7:0] PRE_110 = 8'hC0;
	localparam logic [7:0] PRE_111 = 8'hE0;

	localparam logic [3:0] PRE_N1 = 4'd1;
	localparam logic [3:0] PRE_N2 = 4'd2;
	localparam logic [3:0] PRE_N3 = 4'd3;
	localparam logic [3:0] SEG_FULL = 4'd8;

	localparam logic [5:0] WORD_W = 6'd32;

endpackage

`default_nettype wire

// ===== src/tvbp_merge.sv =====
// byte merge unit: appends a left-aligned segment of up to eight bits to the partial byte
// depends on tvbp_pkg
`default_nettype none

module tvbp_merge (
	input  logic [7:0]       part,
	input  logic [2:0]       fill,
	input  logic [7:0]       seg,
	input  logic [3:0]       seg_n,
	output tvbp_pkg::merge_t res
);

	logic [15:0] joined;
	logic [4:0]  total;

	// segment bits below seg_n and partial bits below fill are zero
	assign joined = {part, 8'h00} | ({seg, 8'h00} >> fill);
	assign total  = {2'b00, fill} + {1'b0, seg_n};

	assign res.emit = total[3];
	assign res.data = joined[15:8];
	assign res.part = total[3] ? joined[7:0] : joined[15:8];
	assign res.fill = total[2:0];

endmodule

`default_nettype wire

// ===== src/typed_value_bit_packer_unit.sv =====
// top level of the typed value bit packer: decode, sequencer, pending byte, output register
// depends on tvbp_pkg and tvbp_merge
//
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    opcode, value, raw_width
// out      output     out_valid/out_ready  out_byte, last_of_run
//
// an item is accepted, takes one step per segment and is closed in the done state.
// a segment is a prefix, one payload byte, one varint group or a flush; the single byte
// merge unit takes one segment per cycle while the output is not stalled. worst case is a
// negative 64-bit svarint with ten varint groups. in_ready is high only between items.
// a stalled output holds the sequencer in place; reset clears the partial byte and fill.
`default_nettype none

module typed_value_bit_packer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [63:0] value,
	input  logic [5:0]  raw_width,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_of_run
);

	tvbp_pkg::state_t state_q;
	tvbp_pkg::state_t nxt_q;
	logic [7:0]  part_q;
	logic [2:0]  fill_q;
	logic [7:0]  pre_q;
	logic [3:0]  pre_n_q;
	logic [31:0] pay_q;
	logic [5:0]  rem_q;
	logic [63:0] var_q;
	logic [7:0]  pend_q;
	logic        pend_v_q;
	logic        out_v_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;

	// decode
	tvbp_pkg::state_t nxt_d;
	logic [7:0]  pre_d;
	logic [3:0]  pre_n_d;
	logic [5:0]  w_d;
	logic [63:0] var_d;
	logic [31:0] v32;
	logic [31:0] pay_d;
	logic        accept;

	// step
	logic [7:0]       seg;
	logic [3:0]       seg_n;
	tvbp_pkg::merge_t mres;
	logic             out_free;
	logic             stepping;
	logic             step_go;
	logic             done_go;
	logic             push;
	logic             push_last;
	logic             var_last;

	assign v32      = value[31:0];
	assign in_ready = (state_q == tvbp_pkg::S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		pre_d   = tvbp_pkg::PRE_0;
		pre_n_d = 4'd0;
		w_d     = tvbp_pkg::WORD_W;
		var_d   = value;
		nxt_d   = tvbp_pkg::S_DONE;
		unique case (tvbp_pkg::opcode_t'(opcode))
			tvbp_pkg::OP_RAW: begin
				w_d   = (raw_width > tvbp_pkg::WORD_W) ? tvbp_pkg::WORD_W : raw_width;
				nxt_d = (raw_width == 6'd0) ? tvbp_pkg::S_DONE : tvbp_pkg::S_PAYLOAD;
			end
			tvbp_pkg::OP_BIT: begin
				pre_d   = {value[0], 7'b0};
				pre_n_d = tvbp_pkg::PRE_N1;
			end
			tvbp_pkg::OP_UVARINT: begin
				nxt_d = tvbp_pkg::S_VARINT;
			end
			tvbp_pkg::OP_SVARINT: begin
				pre_d   = {value[63], 7'b0};
				pre_n_d = tvbp_pkg::PRE_N1;
				var_d   = value[63] ? (64'd0 - value) : value;
				nxt_d   = tvbp_pkg::S_VARINT;
			end
			tvbp_pkg::OP_ID: begin
				nxt_d = tvbp_pkg::S_PAYLOAD;
				if (v32 == 32'd1) begin
					pre_d   = tvbp_pkg::PRE_0;
					pre_n_d = tvbp_pkg::PRE_N1;
					nxt_d   = tvbp_pkg::S_DONE;
				end else if (v32 < 32'd16) begin
					pre_d   = tvbp_pkg::PRE_10;
					pre_n_d = tvbp_pkg::PRE_N2;
					w_d     = 6'd4;
				end else if (v32 < 32'd8192) begin
					pre_d   = tvbp_pkg::PRE_110;
					pre_n_d = tvbp_pkg::PRE_N3;
					w_d     = 6'd13;
				end else begin
					pre_d   = tvbp_pkg::PRE_111;
					pre_n_d = tvbp_pkg::PRE_N3;
				end
			end
			tvbp_pkg::OP_POS: begin
				nxt_d = tvbp_pkg::S_PAYLOAD;
				if (v32 < 32'd16) begin
					pre_d   = tvbp_pkg::PRE_0;
					pre_n_d = tvbp_pkg::PRE_N1;
					w_d     = 6'd4;
				end else if (v32 < 32'd4096) begin
					pre_d   = tvbp_pkg::PRE_10;
					pre_n_d = tvbp_pkg::PRE_N2;
					w_d     = 6'd12;
				end else if (v32 < 32'd1048576) begin
					pre_d   = tvbp_pkg::PRE_110;
					pre_n_d = tvbp_pkg::PRE_N3;
					w_d     = 6'd20;
				end else begin
					pre_d   = tvbp_pkg::PRE_111;
					pre_n_d = tvbp_pkg::PRE_N3;
				end
			end
			tvbp_pkg::OP_ENUM: begin
				nxt_d = tvbp_pkg::S_PAYLOAD;
				if (v32 < 32'd32) begin
					pre_d   = tvbp_pkg::PRE_0;
					pre_n_d = tvbp_pkg::PRE_N1;
					w_d     = 6'd5;
				end else if (v32 < 32'd256) begin
					pre_d   = tvbp_pkg::PRE_10;
					pre_n_d = tvbp_pkg::PRE_N2;
					w_d     = 6'd8;
				end else if (v32 < 32'd8192) begin
					pre_d   = tvbp_pkg::PRE_110;
					pre_n_d = tvbp_pkg::PRE_N3;
					w_d     = 6'd13;
				end else begin
					pre_d   = tvbp_pkg::PRE_111;
					pre_n_d = tvbp_pkg::PRE_N3;
				end
			end
			tvbp_pkg::OP_FLUSH: begin
				nxt_d = tvbp_pkg::S_FLUSH;
			end
		endcase
	end

	// left-align the payload so each step takes the top byte
	assign pay_d = v32 << 5'(tvbp_pkg::WORD_W - w_d);

	// segment select for the shared merge unit
	assign var_last = (var_q[63:7] == 57'd0);

	always_comb begin
		seg      = 8'h00;
		seg_n    = 4'd0;
		stepping = 1'b0;
		unique case (state_q)
			tvbp_pkg::S_PREFIX: begin
				seg      = pre_q;
				seg_n    = pre_n_q;
				stepping = 1'b1;
			end
			tvbp_pkg::S_PAYLOAD: begin
				seg      = pay_q[31:24];
				seg_n    = (rem_q >= 6'd8) ? tvbp_pkg::SEG_FULL : rem_q[3:0];
				stepping = 1'b1;
			end
			tvbp_pkg::S_VARINT: begin
				seg      = {var_last, var_q[6:0]};
				seg_n    = tvbp_pkg::SEG_FULL;
				stepping = 1'b1;
			end
			tvbp_pkg::S_FLUSH: begin
				// zero padding up to the byte boundary
				seg      = 8'h00;
				seg_n    = (fill_q == 3'd0) ? 4'd0 : (tvbp_pkg::SEG_FULL - {1'b0, fill_q});
				stepping = 1'b1;
			end
			tvbp_pkg::S_IDLE, tvbp_pkg::S_DONE: begin
				stepping = 1'b0;
			end
			default: begin
				stepping = 1'b0;
			end
		endcase
	end

	tvbp_merge u_merge (
		.part  (part_q),
		.fill  (fill_q),
		.seg   (seg),
		.seg_n (seg_n),
		.res   (mres)
	);

	// pending byte is held back one step so the last byte of an item can be marked
	assign out_free  = !out_v_q || out_ready;
	assign step_go   = stepping && (!pend_v_q || out_free);
	assign done_go   = (state_q == tvbp_pkg::S_DONE) && (!pend_v_q || out_free);
	assign push      = (step_go && mres.emit && pend_v_q) || (done_go && pend_v_q);
	assign push_last = done_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tvbp_pkg::S_IDLE;
			nxt_q    <= tvbp_pkg::S_DONE;
			part_q   <= 8'h00;
			fill_q   <= 3'd0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (accept) begin
				nxt_q   <= nxt_d;
				state_q <= (pre_n_d != 4'd0) ? tvbp_pkg::S_PREFIX : nxt_d;
			end
			if (step_go) begin
				part_q <= mres.part;
				fill_q <= mres.fill;
				if (mres.emit) begin
					pend_v_q <= 1'b1;
				end
				unique case (state_q)
					tvbp_pkg::S_PREFIX: begin
						state_q <= nxt_q;
					end
					tvbp_pkg::S_PAYLOAD: begin
						if (rem_q <= 6'd8) begin
							state_q <= tvbp_pkg::S_DONE;
						end
					end
					tvbp_pkg::S_VARINT: begin
						if (var_last) begin
							state_q <= tvbp_pkg::S_DONE;
						end
					end
					tvbp_pkg::S_FLUSH: begin
						state_q <= tvbp_pkg::S_DONE;
					end
					default: begin
						state_q <= state_q;
					end
				endcase
			end
			if (done_go) begin
				pend_v_q <= 1'b0;
				state_q  <= tvbp_pkg::S_IDLE;
			end
			if (push) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pre_q   <= pre_d;
			pre_n_q <= pre_n_d;
			pay_q   <= pay_d;
			rem_q   <= w_d;
			var_q   <= var_d;
		end
		if (step_go) begin
			if (state_q == tvbp_pkg::S_PAYLOAD) begin
				pay_q <= {pay_q[23:0], 8'h00};
				rem_q <= rem_q - {2'b00, seg_n};
			end
			if (state_q == tvbp_pkg::S_VARINT) begin
				var_q <= {7'd0, var_q[63:7]};
			end
			if (mres.emit) begin
				pend_q <= mres.data;
			end
		end
		if (push) begin
			out_byte_q <= pend_q;
			out_last_q <= push_last;
		end
	end

	assign out_valid   = out_v_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = out_last_q;

	// no byte is held back between items
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tvbp_pkg::S_IDLE) |-> !pend_v_q)
		else $error("pending byte left over after item");

	// a zero fill count leaves the partial byte clear
	a_empty_part: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == 3'd0) |-> (part_q == 8'h00))
		else $error("partial byte not clear with zero fill");

	// a flush step leaves the stream byte-aligned
	a_flush_aligns: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tvbp_pkg::S_FLUSH && step_go) |=> (fill_q == 3'd0))
		else $error("flush left bits pending");

	// a byte is only pushed while the output slot can take it
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("output register overwritten");

endmodule

`default_nettype wire
